// File: rtl/core/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic form: explicit clock and active-low reset.
`define FSA_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Default form: the block's own clock and reset.
`define FSA_ASSERT(label, prop, msg) \
  `FSA_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

// File: rtl/core/fsa_pkg.sv
package fsa_pkg;

  localparam int unsigned NumSlotsDef = 256;

  typedef enum logic [0:0] {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_REFUSED = 2'd1,
    ST_RANGE   = 2'd2
  } status_e;

endpackage

// File: rtl/core/fifo_free_list_slot_allocator.sv
// Slot allocator. Hands out slot indices 0..NUM_SLOTS-1 and takes them back.
// An allocate beat returns the oldest free slot; a free beat returns a slot
// to the back of the free queue, so slots are recycled in first-freed,
// first-reused order. After reset every slot is free, queued in index order.
// One free slot is always held back: an allocate is refused whenever only one
// slot remains free, so at most NUM_SLOTS-1 slots are ever in use. Freeing a
// slot that is not in use is refused, and a free index >= NUM_SLOTS reports
// out of range; neither changes any state. slot_out is zero unless the
// status is done; used_count is the count after the request.
// Rate: one request per clock cycle sustained while results are taken;
// requests pass the input then the result register. The free queue memory
// is read ahead on the next head address by its registered read port, so
// the head slot is always ready. No clearing pass after reset: unwritten
// queue entries read as their own address, tracked by a write-wrap flag.
module fifo_free_list_slot_allocator #(
  parameter int unsigned NUM_SLOTS = fsa_pkg::NumSlotsDef,
  localparam int unsigned SlotW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1,
  localparam int unsigned CntW  = $clog2(NUM_SLOTS + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // request channel
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  fsa_pkg::req_e        req_type_i,
  input  logic [SlotW-1:0]     slot_index_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output fsa_pkg::status_e     status_o,
  output logic [SlotW-1:0]     slot_out_o,
  output logic [CntW-1:0]      used_count_o
);
  import fsa_pkg::*;

  localparam logic [SlotW-1:0] LastPtr = SlotW'(NUM_SLOTS - 1);

  // ---------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------
  logic             a_valid_q;
  req_e             a_type_q;
  logic [SlotW-1:0] a_idx_q;

  // Result register
  logic             out_valid_q;
  status_e          status_q;
  logic [SlotW-1:0] slot_q;
  logic [CntW-1:0]  count_q;

  // Advance the input register into the result register when it has room.
  logic adv;
  logic fire;

  assign adv        = !out_valid_q || out_ready_i;
  assign fire       = a_valid_q && adv;
  assign in_ready_o = !a_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      a_type_q <= req_type_i;
      a_idx_q  <= slot_index_i;
    end
  end

  // ---------------------------------------------------------------------
  // Allocator state
  // ---------------------------------------------------------------------
  // Free queue: rd_ptr names the head, wr_ptr the next append position.
  logic [SlotW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [SlotW-1:0]     wr_ptr_q, wr_ptr_d;
  logic                 wrapped_q, wrapped_d;   // wr_ptr has gone round once
  logic [CntW-1:0]      free_cnt_q, free_cnt_d;
  logic [CntW-1:0]      used_cnt_q, used_cnt_d;
  logic [NUM_SLOTS-1:0] used_q, used_d;         // one in-use flag per slot

  // Queue memory and its prefetched head
  logic [SlotW-1:0] fifo_mem [NUM_SLOTS];
  logic [SlotW-1:0] rd_data_q;
  logic             head_written_q;
  logic [SlotW-1:0] head;

  // Until the append pointer has covered an entry it still holds its
  // reset contents, i.e. its own index.
  assign head = head_written_q ? rd_data_q : rd_ptr_q;

  // ---------------------------------------------------------------------
  // Request decode
  // ---------------------------------------------------------------------
  logic    in_range;
  logic    pop;
  logic    push;
  status_e res_status;
  logic [SlotW-1:0] res_slot;

  assign in_range = CntW'(a_idx_q) < CntW'(NUM_SLOTS);

  always_comb begin
    pop        = 1'b0;
    push       = 1'b0;
    res_status = ST_REFUSED;
    res_slot   = '0;
    if (fire) begin
      unique case (a_type_q)
        REQ_ALLOC: begin
          // last free slot is kept back
          if (free_cnt_q != CntW'(1)) begin
            pop        = 1'b1;
            res_status = ST_DONE;
            res_slot   = head;
          end
        end
        REQ_FREE: begin
          priority if (!in_range) begin
            res_status = ST_RANGE;
          end else if (used_q[a_idx_q]) begin
            push       = 1'b1;
            res_status = ST_DONE;
            res_slot   = a_idx_q;
          end else begin
            res_status = ST_REFUSED;
          end
        end
        default: begin
          res_status = ST_REFUSED;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------
  always_comb begin
    rd_ptr_d   = rd_ptr_q;
    wr_ptr_d   = wr_ptr_q;
    wrapped_d  = wrapped_q;
    free_cnt_d = free_cnt_q;
    used_cnt_d = used_cnt_q;
    used_d     = used_q;
    if (pop) begin
      rd_ptr_d     = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + SlotW'(1);
      free_cnt_d   = free_cnt_q - CntW'(1);
      used_cnt_d   = used_cnt_q + CntW'(1);
      used_d[head] = 1'b1;
    end
    if (push) begin
      wr_ptr_d        = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + SlotW'(1);
      wrapped_d       = wrapped_q || (wr_ptr_q == LastPtr);
      free_cnt_d      = free_cnt_q + CntW'(1);
      used_cnt_d      = used_cnt_q - CntW'(1);
      used_d[a_idx_q] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q       <= '0;
      wr_ptr_q       <= '0;
      wrapped_q      <= 1'b0;
      free_cnt_q     <= CntW'(NUM_SLOTS);
      used_cnt_q     <= '0;
      used_q         <= '0;
      head_written_q <= 1'b0;
    end else begin
      rd_ptr_q       <= rd_ptr_d;
      wr_ptr_q       <= wr_ptr_d;
      wrapped_q      <= wrapped_d;
      free_cnt_q     <= free_cnt_d;
      used_cnt_q     <= used_cnt_d;
      used_q         <= used_d;
      head_written_q <= wrapped_d || (rd_ptr_d < wr_ptr_d);
    end
  end

  // Queue memory: one write, one registered read per cycle. The read runs
  // on the next head address. A push never lands on the live head, since
  // a push needs a slot in use, so the free queue is never full then.
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_mem[wr_ptr_q] <= a_idx_q;
    end
    rd_data_q <= fifo_mem[rd_ptr_d];
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q <= res_status;
      slot_q   <= res_slot;
      count_q  <= used_cnt_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign slot_out_o   = slot_q;
  assign used_count_o = count_q;

endmodule

// File: rtl/core/fsa_checker.sv
`include "assert_macros.svh"

module fsa_checker #(
  parameter int unsigned NUM_SLOTS = fsa_pkg::NumSlotsDef,
  localparam int unsigned SlotW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1,
  localparam int unsigned CntW  = $clog2(NUM_SLOTS + 1)
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input fsa_pkg::status_e status_o,
  input logic [SlotW-1:0] slot_out_o,
  input logic [CntW-1:0]  used_count_o
);
  import fsa_pkg::*;

  // used count of the last delivered result beat (zero after reset)
  logic [CntW-1:0] last_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_cnt_q <= '0;
    end else if (out_valid_o && out_ready_i) begin
      last_cnt_q <= used_count_o;
    end
  end

  `FSA_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) && $stable(slot_out_o) && $stable(used_count_o), "result beat changed while stalled")

  `FSA_ASSERT(a_slot_zero, out_valid_o && status_o != ST_DONE |-> slot_out_o == '0, "slot_out not zero on refused request")

  `FSA_ASSERT(a_held_back, out_valid_o |-> used_count_o < CntW'(NUM_SLOTS), "last free slot was handed out")

  `FSA_ASSERT(a_cnt_kept, out_valid_o && status_o != ST_DONE |-> used_count_o == last_cnt_q, "used count moved on refused request")

  `FSA_ASSERT(a_cnt_step, out_valid_o && status_o == ST_DONE |-> (used_count_o == last_cnt_q + CntW'(1)) || (used_count_o + CntW'(1) == last_cnt_q), "used count not stepped by one")

endmodule

bind fifo_free_list_slot_allocator fsa_checker #(
  .NUM_SLOTS(NUM_SLOTS)
) u_fsa_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .status_o     (status_o),
  .slot_out_o   (slot_out_o),
  .used_count_o (used_count_o)
);
